// File: sv/thrm_pkg.sv
// ----------------------------------------------------------------------------
// thrm_pkg
// Shared types and constants for the tip history ring matcher: field widths,
// result codes, register map and the sequencer state type.
// ----------------------------------------------------------------------------
package thrm_pkg;

    localparam int HASH_W   = 256;
    localparam int WORD_W   = 64;
    localparam int DIFF_W   = 32;
    localparam int TIME_W   = 32;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int CNT_OUT_W = 4;

    // Function codes
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Register map (word index taken from paddr[2])
    localparam logic REG_TIME_SKEW = 1'b0;
    localparam logic [TIME_W-1:0] SKEW_RESET = 32'd7200;

    // Relation codes
    localparam logic [1:0] REL_NONE   = 2'd0;
    localparam logic [1:0] REL_SAME   = 2'd1;
    localparam logic [1:0] REL_BEHIND = 2'd2;
    localparam logic [1:0] REL_AHEAD  = 2'd3;

    // Verdict codes
    localparam logic [1:0] VER_OK          = 2'd0;
    localparam logic [1:0] VER_BITS_DIFFER = 2'd1;
    localparam logic [1:0] VER_TIME_AHEAD  = 2'd2;
    localparam logic [1:0] VER_TIME_BEHIND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_WALK,
        S_DONE
    } t_state;

    // Memory port strobes from the sequencer to the ring store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ring_ctl;

endpackage

// File: sv/thrm_ring.sv
// ----------------------------------------------------------------------------
// thrm_ring
// Ring store: one memory of 256-bit hashes and one of difficulty/timestamp
// pairs, both with a registered read. The read hash is compared against the
// key held by the sequencer.
// ----------------------------------------------------------------------------
module thrm_ring
    import thrm_pkg::*;
#(
    parameter int RING_DEPTH = 8,
    localparam int SW = $clog2(RING_DEPTH)
) (
    input  logic              i_clk,
    input  t_ring_ctl         i_ctl,
    input  logic [SW-1:0]     i_wr_slot,
    input  logic [HASH_W-1:0] i_wr_hash,
    input  logic [DIFF_W-1:0] i_wr_bits,
    input  logic [TIME_W-1:0] i_wr_time,
    input  logic [SW-1:0]     i_rd_slot,
    input  logic [HASH_W-1:0] i_key,
    output logic              o_hit,
    output logic [DIFF_W-1:0] o_rd_bits,
    output logic [TIME_W-1:0] o_rd_time
);

    logic [HASH_W-1:0]        mem_hash [RING_DEPTH];
    logic [DIFF_W+TIME_W-1:0] mem_info [RING_DEPTH];

    logic [HASH_W-1:0]        r_rd_hash;
    logic [DIFF_W+TIME_W-1:0] r_rd_info;

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem_hash[i_wr_slot] <= i_wr_hash;
            mem_info[i_wr_slot] <= {i_wr_bits, i_wr_time};
        end
    end

    // Read one entry, data registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_hash <= mem_hash[i_rd_slot];
            r_rd_info <= mem_info[i_rd_slot];
        end
    end

    // Compare against the key
    assign o_hit     = (r_rd_hash == i_key);
    assign o_rd_bits = r_rd_info[DIFF_W+TIME_W-1:TIME_W];
    assign o_rd_time = r_rd_info[TIME_W-1:0];

endmodule

// File: sv/tip_history_ring_matcher.sv
// ----------------------------------------------------------------------------
// tip_history_ring_matcher
// Ring of recent tip hashes with difficulty and timestamp; stores pushes,
// classifies queries against it and reports the newest tip on every result.
// ----------------------------------------------------------------------------
// One item at a time: busy stays high from the transfer until the result
// strobe has been shown. A push goes through S_PUSH and then S_DONE; a query
// on an empty ring goes straight to S_DONE. A query walks the ring from the
// newest entry back through the single read port of the ring memory, one
// entry per cycle with the compare in the cycle after the read, and compares
// at most RING_DEPTH entries. Each result is shown on o_valid for exactly one
// cycle and cannot be held off.
// Configuration writes are only to be made while busy is low.
module tip_history_ring_matcher
    import thrm_pkg::*;
#(
    parameter int RING_DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // Command
    input  logic              start,
    output logic              busy,
    input  logic              i_func,
    input  logic [WORD_W-1:0] i_tip_word0,
    input  logic [WORD_W-1:0] i_tip_word1,
    input  logic [WORD_W-1:0] i_tip_word2,
    input  logic [WORD_W-1:0] i_tip_word3,
    input  logic [DIFF_W-1:0] i_difficulty_bits,
    input  logic [TIME_W-1:0] i_timestamp,
    // Result
    output logic              o_valid,
    output logic [1:0]        o_relation,
    output logic [1:0]        o_verdict,
    output logic              o_has_local,
    output logic [CNT_OUT_W-1:0] o_stored_count,
    output logic [WORD_W-1:0] o_newest_word0,
    output logic [WORD_W-1:0] o_newest_word1,
    output logic [WORD_W-1:0] o_newest_word2,
    output logic [WORD_W-1:0] o_newest_word3
);

    localparam int SW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    t_state r_state, n_state;

    logic [TIME_W-1:0] r_skew;
    logic [HASH_W-1:0] r_hash;
    logic [DIFF_W-1:0] r_bits;
    logic [TIME_W-1:0] r_time;
    logic [HASH_W-1:0] r_newest;
    logic [SW-1:0]     r_newest_slot;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_k;
    logic              r_pend;
    logic              r_pend_first;
    logic [1:0]        r_rel;
    logic [1:0]        r_ver;

    logic              accept;
    logic              cfg_wr;
    t_ring_ctl         ring_ctl;
    logic [SW-1:0]     wr_slot;
    logic [SW-1:0]     rd_slot;
    logic [SW-1:0]     k_slot;
    logic              ring_hit;
    logic [DIFF_W-1:0] rd_bits;
    logic [TIME_W-1:0] rd_time;
    logic              dup_push;
    logic              walk_hit;
    logic              walk_last;
    logic [TIME_W:0]   lim_hi;
    logic [TIME_W:0]   lim_lo;
    logic [1:0]        verdict;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_TIME_SKEW) ? r_skew : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skew <= SKEW_RESET;
        end else if (cfg_wr && paddr[2] == REG_TIME_SKEW) begin
            r_skew <= pwdata;
        end
    end

    assign accept = start && !busy;

    // Push: drop a duplicate of the newest tip, else advance the slot
    assign dup_push = (r_count != '0) && (r_hash == r_newest);
    always_comb begin
        if (r_count == '0) begin
            wr_slot = '0;
        end else if (r_newest_slot == SW'(RING_DEPTH - 1)) begin
            wr_slot = '0;
        end else begin
            wr_slot = r_newest_slot + 1'b1;
        end
    end

    // Walk: read slot newest - k, wrapping round the ring
    assign k_slot = r_k[SW-1:0];
    always_comb begin
        if (r_newest_slot >= k_slot) begin
            rd_slot = r_newest_slot - k_slot;
        end else begin
            rd_slot = r_newest_slot - k_slot + SW'(RING_DEPTH);
        end
    end

    assign walk_hit  = r_pend && ring_hit;
    assign walk_last = r_pend && !ring_hit && (r_k >= r_count);

    // Check difficulty and time against the newest entry at 33 bits
    assign lim_hi = {1'b0, rd_time} + {1'b0, r_skew};
    assign lim_lo = {1'b0, r_time} + {1'b0, r_skew};
    always_comb begin
        priority if (r_bits != rd_bits) begin
            verdict = VER_BITS_DIFFER;
        end else if ({1'b0, r_time} > lim_hi) begin
            verdict = VER_TIME_AHEAD;
        end else if ({1'b0, rd_time} > lim_lo) begin
            verdict = VER_TIME_BEHIND;
        end else begin
            verdict = VER_OK;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_PUSH) begin
                        n_state = S_PUSH;
                    end else if (r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_PUSH: n_state = S_DONE;
            S_WALK: begin
                if (walk_hit || walk_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        ring_ctl = '0;
        busy     = 1'b1;
        o_valid  = 1'b0;
        unique case (r_state)
            S_IDLE: busy = 1'b0;
            S_PUSH: ring_ctl.wr_en = !dup_push;
            S_WALK: ring_ctl.rd_en = (r_k < r_count);
            S_DONE: o_valid = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the item on transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hash <= {i_tip_word0, i_tip_word1, i_tip_word2, i_tip_word3};
            r_bits <= i_difficulty_bits;
            r_time <= i_timestamp;
        end
    end

    // Ring pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest_slot <= '0;
            r_count       <= '0;
        end else if (ring_ctl.wr_en) begin
            r_newest_slot <= wr_slot;
            if (r_count != CW'(RING_DEPTH)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Copy of the newest hash for the result
    always_ff @(posedge i_clk) begin
        if (ring_ctl.wr_en) begin
            r_newest <= r_hash;
        end
    end

    // Walk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k          <= '0;
            r_pend       <= 1'b0;
            r_pend_first <= 1'b0;
        end else if (accept) begin
            r_k          <= '0;
            r_pend       <= 1'b0;
            r_pend_first <= 1'b0;
        end else if (r_state == S_WALK) begin
            r_pend       <= ring_ctl.rd_en;
            r_pend_first <= (r_k == '0);
            if (ring_ctl.rd_en) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // Relation and verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel <= REL_NONE;
            r_ver <= VER_OK;
        end else if (accept) begin
            r_rel <= REL_NONE;
            r_ver <= VER_OK;
        end else if (r_state == S_WALK) begin
            if (r_pend && r_pend_first) begin
                r_ver <= verdict;
            end
            if (walk_hit) begin
                r_rel <= r_pend_first ? REL_SAME : REL_BEHIND;
            end else if (walk_last) begin
                r_rel <= REL_AHEAD;
            end
        end
    end

    thrm_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_ctl     (ring_ctl),
        .i_wr_slot (wr_slot),
        .i_wr_hash (r_hash),
        .i_wr_bits (r_bits),
        .i_wr_time (r_time),
        .i_rd_slot (rd_slot),
        .i_key     (r_hash),
        .o_hit     (ring_hit),
        .o_rd_bits (rd_bits),
        .o_rd_time (rd_time)
    );

    // Result fields
    assign o_relation     = r_rel;
    assign o_verdict      = r_ver;
    assign o_has_local    = (r_count != '0);
    assign o_stored_count = CNT_OUT_W'(r_count);
    assign o_newest_word0 = o_has_local ? r_newest[4*WORD_W-1:3*WORD_W] : '0;
    assign o_newest_word1 = o_has_local ? r_newest[3*WORD_W-1:2*WORD_W] : '0;
    assign o_newest_word2 = o_has_local ? r_newest[2*WORD_W-1:WORD_W]   : '0;
    assign o_newest_word3 = o_has_local ? r_newest[WORD_W-1:0]          : '0;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RING_DEPTH))
        else $error("entry count beyond ring depth");

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    a_no_read_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ring_ctl.wr_en && ring_ctl.rd_en))
        else $error("ring read and write in the same cycle");
`endif

endmodule
